// ===== rtl/bmsq_pkg.sv =====
// shared types, constants and helpers for the buzzer melody sequencer
// no dependencies; every other file of the block but bmsq_ram uses this package
package bmsq_pkg;

	// note store geometry, slots per song must be a power of two
	localparam int NOTE_SLOTS = 256;
	localparam int POS_W      = $clog2(NOTE_SLOTS);
	localparam int LEN_W      = POS_W + 1;
	localparam int ADDR_W     = POS_W + 1;
	localparam int STORE_DEPTH = 2 * NOTE_SLOTS;

	// field widths
	localparam int FREQ_W     = 11;
	localparam int MS_W       = 12;
	localparam int LENREG_W   = 9;
	localparam int SLOT_W     = 8;
	localparam int MODE_W     = 3;
	localparam int PPOS_W     = 8;
	localparam int ENTRY_W    = FREQ_W + MS_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	// register reset values
	localparam logic [LENREG_W-1:0] RST_SONG1_LEN = LENREG_W'(44);
	localparam logic [LENREG_W-1:0] RST_SONG2_LEN = LENREG_W'(164);
	localparam logic [FREQ_W-1:0]   RST_WARN_FREQ = FREQ_W'(880);
	localparam logic [MS_W-1:0]     RST_WARN_MS   = MS_W'(500);
	localparam logic [FREQ_W-1:0]   RST_ERR_FREQ  = FREQ_W'(1046);
	localparam logic [MS_W-1:0]     RST_ERR_MS    = MS_W'(300);
	localparam logic [MS_W-1:0]     RST_GAP_MS    = MS_W'(300);

	typedef enum logic [MODE_W-1:0] {
		MODE_SILENT  = 3'd0,
		MODE_SONG1   = 3'd1,
		MODE_SONG2   = 3'd2,
		MODE_WARNING = 3'd3,
		MODE_ERROR   = 3'd4
	} mode_t;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_WRITE = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SONG1_LEN = 3'd0,
		CFG_SONG2_LEN = 3'd1,
		CFG_WARN_FREQ = 3'd2,
		CFG_WARN_MS   = 3'd3,
		CFG_ERR_FREQ  = 3'd4,
		CFG_ERR_MS    = 3'd5,
		CFG_GAP_MS    = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [LENREG_W-1:0] song1_len;
		logic [LENREG_W-1:0] song2_len;
		logic [FREQ_W-1:0]   warn_freq;
		logic [MS_W-1:0]     warn_ms;
		logic [FREQ_W-1:0]   err_freq;
		logic [MS_W-1:0]     err_ms;
		logic [MS_W-1:0]     gap_ms;
	} cfg_t;

	typedef struct packed {
		logic                op;
		logic [MODE_W-1:0]   requested_mode;
		logic                note_song;
		logic [SLOT_W-1:0]   note_slot;
		logic [FREQ_W-1:0]   note_freq;
		logic [MS_W-1:0]     note_ms;
	} item_t;

	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic [MS_W-1:0]   ms;
	} entry_t;

	// result of one item as it leaves the sequencer
	typedef struct packed {
		logic [FREQ_W-1:0] tone;
		logic              from_mem;
		logic [POS_W-1:0]  pos;
		logic              gap;
	} res_t;

	typedef struct packed {
		mode_t            mode;
		logic             mem_live;
		logic [POS_W-1:0] pos;
		logic [MS_W-1:0]  gap_left;
	} status_t;

	// song length register to the number of notes actually played
	function automatic logic [LEN_W-1:0] song_len(input logic [LENREG_W-1:0] r);
		logic [LEN_W-1:0] len;
		if (r == '0) begin
			len = LEN_W'(1);
		end else if (int'(r) > NOTE_SLOTS) begin
			len = LEN_W'(NOTE_SLOTS);
		end else begin
			len = LEN_W'(r);
		end
		return len;
	endfunction

endpackage

// ===== rtl/bmsq_if.sv =====
// channel interfaces of the buzzer melody sequencer: items, results, register writes
// depends on bmsq_pkg for field widths

interface bmsq_in_if;
	logic                           valid;
	logic                           ready;
	logic                           op;
	logic [bmsq_pkg::MODE_W-1:0]    requested_mode;
	logic                           note_song;
	logic [bmsq_pkg::SLOT_W-1:0]    note_slot;
	logic [bmsq_pkg::FREQ_W-1:0]    note_freq;
	logic [bmsq_pkg::MS_W-1:0]      note_ms;

	modport source (output valid, op, requested_mode, note_song, note_slot, note_freq,
		note_ms, input ready);
	modport sink (input valid, op, requested_mode, note_song, note_slot, note_freq,
		note_ms, output ready);
endinterface

interface bmsq_out_if;
	logic                           valid;
	logic                           ready;
	logic [bmsq_pkg::FREQ_W-1:0]    tone_freq;
	logic [bmsq_pkg::PPOS_W-1:0]    playing_pos;
	logic                           in_gap;

	modport source (output valid, tone_freq, playing_pos, in_gap, input ready);
	modport sink (input valid, tone_freq, playing_pos, in_gap, output ready);
endinterface

interface bmsq_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [bmsq_pkg::CFG_IDX_W-1:0]   index;
	logic [bmsq_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/bmsq_ram.sv =====
// generic single-clock ram: one write port, one read port with registered read data
// no dependencies
module bmsq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/bmsq_cfg.sv =====
// configuration register file of the buzzer melody sequencer
// depends on bmsq_pkg and bmsq_cfg_if
module bmsq_cfg (
	input  logic           clk,
	input  logic           arst_n,
	bmsq_cfg_if.sink       cfg,
	output bmsq_pkg::cfg_t regs
);
	import bmsq_pkg::*;

	cfg_t regs_q;

	// writes are always taken
	assign cfg.ready = 1'b1;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.song1_len <= RST_SONG1_LEN;
			regs_q.song2_len <= RST_SONG2_LEN;
			regs_q.warn_freq <= RST_WARN_FREQ;
			regs_q.warn_ms   <= RST_WARN_MS;
			regs_q.err_freq  <= RST_ERR_FREQ;
			regs_q.err_ms    <= RST_ERR_MS;
			regs_q.gap_ms    <= RST_GAP_MS;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_SONG1_LEN: regs_q.song1_len <= cfg.data[LENREG_W-1:0];
				CFG_SONG2_LEN: regs_q.song2_len <= cfg.data[LENREG_W-1:0];
				CFG_WARN_FREQ: regs_q.warn_freq <= cfg.data[FREQ_W-1:0];
				CFG_WARN_MS:   regs_q.warn_ms   <= cfg.data[MS_W-1:0];
				CFG_ERR_FREQ:  regs_q.err_freq  <= cfg.data[FREQ_W-1:0];
				CFG_ERR_MS:    regs_q.err_ms    <= cfg.data[MS_W-1:0];
				CFG_GAP_MS:    regs_q.gap_ms    <= cfg.data[MS_W-1:0];
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

// ===== rtl/bmsq_ctrl.sv =====
// sequencer core: mode, position and timers, plus the note store ram
// depends on bmsq_pkg and bmsq_ram
module bmsq_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          acc,
	input  bmsq_pkg::item_t               item,
	input  bmsq_pkg::cfg_t                cfg,
	output bmsq_pkg::res_t                res,
	output logic [bmsq_pkg::FREQ_W-1:0]   rd_freq,
	output bmsq_pkg::status_t             status
);
	import bmsq_pkg::*;

	mode_t             mode_q, mode_d, req_m, ld_mode;
	logic [POS_W-1:0]  pos_q, pos_d, ld_pos, adv_pos, song_pos;
	logic [MS_W-1:0]   hold_q, hold_d, el_q, el_d, gap_q, gap_d, hold_eff;
	logic [FREQ_W-1:0] tone_q, tone_d;
	logic              live_q, live_d;
	logic              ld, gap_flag;
	logic [LEN_W-1:0]  cur_len, ld_len, adv_next;

	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	entry_t            ram_wdata, ram_rdata;

	// note store, both songs back to back
	bmsq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// note writes go straight to the store
	assign ram_we          = acc && (item.op == OP_WRITE) && (int'(item.note_slot) < NOTE_SLOTS);
	assign ram_waddr       = {item.note_song, POS_W'(item.note_slot)};
	assign ram_wdata.freq  = item.note_freq;
	assign ram_wdata.ms    = item.note_ms;

	// the current song note lives in the read register until something else loads
	assign hold_eff = live_q ? ram_rdata.ms : hold_q;
	assign rd_freq  = ram_rdata.freq;

	// requests outside the mode list mean silent
	always_comb begin
		if (item.requested_mode inside {[MODE_SILENT:MODE_ERROR]}) begin
			req_m = mode_t'(item.requested_mode);
		end else begin
			req_m = MODE_SILENT;
		end
	end

	// next position on advance
	always_comb begin
		case (mode_q)
			MODE_SONG1: cur_len = song_len(cfg.song1_len);
			MODE_SONG2: cur_len = song_len(cfg.song2_len);
			default:    cur_len = LEN_W'(2);
		endcase
		adv_next = {1'b0, pos_q} + LEN_W'(1);
		adv_pos  = (adv_next >= cur_len) ? '0 : adv_next[POS_W-1:0];
	end

	// length and clamped position for a song load
	assign ld_len   = song_len((ld_mode == MODE_SONG1) ? cfg.song1_len : cfg.song2_len);
	assign song_pos = ({1'b0, ld_pos} >= ld_len) ? '0 : ld_pos;

	// tick handling and item load
	always_comb begin
		mode_d    = mode_q;
		pos_d     = pos_q;
		hold_d    = hold_q;
		el_d      = el_q;
		gap_d     = gap_q;
		tone_d    = tone_q;
		live_d    = live_q;
		ld        = 1'b0;
		ld_mode   = mode_q;
		ld_pos    = pos_q;
		gap_flag  = (gap_q != '0);
		ram_re    = 1'b0;
		ram_raddr = '0;

		if (acc && (item.op == OP_TICK)) begin
			if (gap_q != '0) begin
				gap_d    = gap_q - MS_W'(1);
				gap_flag = 1'b1;
				if (gap_q == MS_W'(1)) begin
					ld       = 1'b1;
					gap_flag = 1'b0;
				end
			end else if (req_m != mode_q) begin
				mode_d   = req_m;
				pos_d    = '0;
				el_d     = '0;
				gap_d    = cfg.gap_ms;
				gap_flag = (cfg.gap_ms != '0);
				if (cfg.gap_ms == '0) begin
					ld      = 1'b1;
					ld_mode = req_m;
					ld_pos  = '0;
				end
			end else if (mode_q == MODE_SILENT) begin
				tone_d = '0;
				live_d = 1'b0;
				pos_d  = '0;
			end else if (el_q >= hold_eff) begin
				ld     = 1'b1;
				ld_pos = adv_pos;
			end else begin
				el_d = el_q + MS_W'(1);
			end
		end

		// load tone and hold time of the item at ld_pos
		if (ld) begin
			el_d = '0;
			case (ld_mode)
				MODE_SONG1, MODE_SONG2: begin
					pos_d     = song_pos;
					live_d    = 1'b1;
					ram_re    = 1'b1;
					ram_raddr = {(ld_mode == MODE_SONG2), song_pos};
				end
				MODE_WARNING: begin
					pos_d  = ld_pos;
					live_d = 1'b0;
					tone_d = (ld_pos == '0) ? cfg.warn_freq : '0;
					hold_d = cfg.warn_ms;
				end
				MODE_ERROR: begin
					pos_d  = ld_pos;
					live_d = 1'b0;
					tone_d = (ld_pos == '0) ? cfg.err_freq : '0;
					hold_d = cfg.err_ms;
				end
				default: begin
					pos_d  = '0;
					live_d = 1'b0;
					tone_d = '0;
					hold_d = '0;
				end
			endcase
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SILENT;
			pos_q  <= '0;
			hold_q <= '0;
			el_q   <= '0;
			gap_q  <= '0;
			tone_q <= '0;
			live_q <= 1'b0;
		end else begin
			mode_q <= mode_d;
			pos_q  <= pos_d;
			hold_q <= hold_d;
			el_q   <= el_d;
			gap_q  <= gap_d;
			tone_q <= tone_d;
			live_q <= live_d;
		end
	end

	// result of this item, tone resolved from the read register downstream
	assign res.tone     = tone_d;
	assign res.from_mem = live_d;
	assign res.pos      = pos_d;
	assign res.gap      = gap_flag;

	assign status.mode     = mode_q;
	assign status.mem_live = live_q;
	assign status.pos      = pos_q;
	assign status.gap_left = gap_q;

endmodule

// ===== rtl/bmsq_out.sv =====
// result pipeline: one stage that waits for the store read, then the output register
// depends on bmsq_pkg and bmsq_out_if
module bmsq_out (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        acc,
	input  bmsq_pkg::res_t              res,
	input  logic [bmsq_pkg::FREQ_W-1:0] rd_freq,
	output logic                        in_ready,
	bmsq_out_if.source                  result
);
	import bmsq_pkg::*;

	res_t              res_s1;
	logic              vld_s1;
	logic              vld_s2;
	logic [FREQ_W-1:0] tone_s2;
	logic [PPOS_W-1:0] pos_s2;
	logic              gap_s2;
	logic              adv;

	// stage 1 moves when the output register is free or being drained
	assign adv      = vld_s1 && (!vld_s2 || result.ready);
	assign in_ready = !vld_s1 || adv;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (acc) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv) begin
				vld_s2 <= 1'b1;
			end else if (result.ready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	// payload, song tone taken from the store read register on the way out
	always_ff @(posedge clk) begin
		if (acc) begin
			res_s1 <= res;
		end
		if (adv) begin
			tone_s2 <= res_s1.from_mem ? rd_freq : res_s1.tone;
			pos_s2  <= PPOS_W'(res_s1.pos);
			gap_s2  <= res_s1.gap;
		end
	end

	assign result.valid       = vld_s2;
	assign result.tone_freq   = tone_s2;
	assign result.playing_pos = pos_s2;
	assign result.in_gap      = gap_s2;

endmodule

// ===== rtl/buzzer_melody_sequencer_unit.sv =====
// Buzzer melody sequencer. Every accepted item is a 1 ms tick carrying the requested mode
// (silent, song one, song two, warning beep, error beep) or a write of one note into the
// note store, and every item gives one result: the tone in Hz, the note or beep phase
// position and the mode-change gap flag. One item is taken per clock cycle, back to back,
// while the output is not stalled; its result passes the stage-1 and output registers.
// The note store is a 2 x 256 entry ram with one write and one registered read port; a
// song note is read once when it is loaded and then used straight from the read register,
// so that read is what sets the two-stage result pipeline. Store contents are undefined
// until written and not cleared after reset; a never-written note gives undefined output.
// depends on bmsq_pkg, bmsq_if, bmsq_cfg, bmsq_ctrl, bmsq_out
module buzzer_melody_sequencer_unit (
	input  logic       clk,
	input  logic       arst_n,
	bmsq_in_if.sink    item,
	bmsq_out_if.source result,
	bmsq_cfg_if.sink   cfg
);
	import bmsq_pkg::*;

	cfg_t    regs;
	item_t   item_pl;
	res_t    res;
	status_t status;
	logic    acc;
	logic    in_ready;
	logic [FREQ_W-1:0] rd_freq;

	assign acc        = item.valid && in_ready;
	assign item.ready = in_ready;

	assign item_pl.op             = item.op;
	assign item_pl.requested_mode = item.requested_mode;
	assign item_pl.note_song      = item.note_song;
	assign item_pl.note_slot      = item.note_slot;
	assign item_pl.note_freq      = item.note_freq;
	assign item_pl.note_ms        = item.note_ms;

	// configuration registers
	bmsq_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// sequencer core with the note store
	bmsq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.item    (item_pl),
		.cfg     (regs),
		.res     (res),
		.rd_freq (rd_freq),
		.status  (status)
	);

	// result pipeline
	bmsq_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.res      (res),
		.rd_freq  (rd_freq),
		.in_ready (in_ready),
		.result   (result)
	);

	// a tick inside the gap counts it down by one
	a_gap_count: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (item.op == OP_TICK) && (status.gap_left != '0))
		|=> (status.gap_left == $past(status.gap_left) - MS_W'(1)))
		else $error("gap counter did not count down on a tick");

	// a tone from the store outside song mode only survives as the held tone of a gap
	a_live_in_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(status.mem_live && (status.mode != MODE_SONG1) && (status.mode != MODE_SONG2))
		|-> (status.gap_left != '0))
		else $error("store tone in use outside a song and outside a gap");

	// beep modes only have a tone and a silence phase
	a_beep_phase: assert property (@(posedge clk) disable iff (!arst_n)
		((status.mode == MODE_WARNING) || (status.mode == MODE_ERROR))
		|-> (status.pos <= POS_W'(1)))
		else $error("beep phase out of range");

endmodule
